// ----- rtl/irfd_pkg.sv -----
package irfd_pkg;

	// Field widths
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned NOM_W   = 10;
	localparam int unsigned STOP_W  = 16;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 64;

	// Leader mark bounds (exclusive), 10 us units
	localparam logic [LEN_W-1:0] AEHA_MARK_LO = 16'd280;
	localparam logic [LEN_W-1:0] AEHA_MARK_HI = 16'd400;
	localparam logic [LEN_W-1:0] NEC_MARK_LO  = 16'd750;
	localparam logic [LEN_W-1:0] NEC_MARK_HI  = 16'd1000;
	localparam logic [LEN_W-1:0] SONY_MARK_LO = 16'd180;
	localparam logic [LEN_W-1:0] SONY_MARK_HI = 16'd280;

	// Repeat detection on the leader space
	localparam logic [LEN_W-1:0] AEHA_RPT_SPACE = 16'd270;
	localparam logic [LEN_W-1:0] NEC_RPT_SPACE  = 16'd338;

	typedef enum logic [1:0] {
		FMT_UNKNOWN = 2'd0,
		FMT_AEHA    = 2'd1,
		FMT_NEC     = 2'd2,
		FMT_SONY    = 2'd3
	} fmt_t;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_FRAME_END = 3'd1,
		KIND_REPEAT    = 3'd2,
		KIND_UNSUP     = 3'd3,
		KIND_NO_LEADER = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AEHA_ZERO = 3'd0,
		REG_AEHA_ONE  = 3'd1,
		REG_AEHA_STOP = 3'd2,
		REG_NEC_ZERO  = 3'd3,
		REG_NEC_ONE   = 3'd4,
		REG_NEC_STOP  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [NOM_W-1:0]  aeha_zero;
		logic [NOM_W-1:0]  aeha_one;
		logic [STOP_W-1:0] aeha_stop;
		logic [NOM_W-1:0]  nec_zero;
		logic [NOM_W-1:0]  nec_one;
		logic [STOP_W-1:0] nec_stop;
	} cfg_t;

	typedef struct packed {
		logic               in_frame;
		fmt_t               fmt;
		logic [2:0]         bit_idx;
		logic [7:0]         accum;
		logic [COUNT_W-1:0] count;
	} dec_state_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         value;
		logic               done;
		logic [COUNT_W-1:0] total;
		fmt_t               fmt;
	} result_t;

endpackage

// ----- rtl/ir_remote_frame_decoder_top.sv -----
// IR remote frame decoder. Each input transaction is one measured pulse
// (mark and space length in 10 us units, or a timeout flag in s_tuser).
// Idle, the leader mark is classified as AEHA, NEC, SONY or unknown and
// repeat codes, unsupported formats and timeouts are reported; inside a
// frame spaces are decoded LSB first and each finished byte is sent out.
// The block takes one pulse per cycle while the output is not stalled; a
// pulse's result passes the input register, the single decode step and the
// result register before it is on the output. Only pulses that start a frame
// or add a bit without finishing a byte give no output.
// Configuration writes are meant for idle periods only.
module ir_remote_frame_decoder_top #(
	parameter int unsigned MAX_FRAME_BYTES = irfd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // mark_len[15:0], space_len[31:16]
	input  logic        s_tuser,   // no_pulse
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // byte_value[7:0], byte_total[14:8], zero[15]
	output logic [4:0]  m_tuser,   // result_kind[2:0], frame_format[4:3]
	output logic        m_tlast,   // frame_done
	input  logic        cfg_we,
	input  logic [irfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic                          valid_s1;
	logic [irfd_pkg::LEN_W-1:0]    mark_s1, space_s1;
	logic                          none_s1;
	logic                          adv;
	logic                          out_valid_q;
	irfd_pkg::result_t             out_q;
	irfd_pkg::cfg_t                cfg_q;
	irfd_pkg::dec_state_t          state_q, state_nxt;
	irfd_pkg::result_t             result;
	logic                          emit;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aeha_zero <= 10'd42;
			cfg_q.aeha_one  <= 10'd127;
			cfg_q.aeha_stop <= 16'd200;
			cfg_q.nec_zero  <= 10'd56;
			cfg_q.nec_one   <= 10'd169;
			cfg_q.nec_stop  <= 16'd260;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irfd_pkg::REG_AEHA_ZERO: cfg_q.aeha_zero <= cfg_wdata[irfd_pkg::NOM_W-1:0];
				irfd_pkg::REG_AEHA_ONE:  cfg_q.aeha_one  <= cfg_wdata[irfd_pkg::NOM_W-1:0];
				irfd_pkg::REG_AEHA_STOP: cfg_q.aeha_stop <= cfg_wdata;
				irfd_pkg::REG_NEC_ZERO:  cfg_q.nec_zero  <= cfg_wdata[irfd_pkg::NOM_W-1:0];
				irfd_pkg::REG_NEC_ONE:   cfg_q.nec_one   <= cfg_wdata[irfd_pkg::NOM_W-1:0];
				irfd_pkg::REG_NEC_STOP:  cfg_q.nec_stop  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mark_s1  <= s_tdata[15:0];
			space_s1 <= s_tdata[31:16];
			none_s1  <= s_tuser;
		end
	end

	irfd_step #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_step (
		.state    (state_q),
		.cfg      (cfg_q),
		.mark_len (mark_s1),
		.space_len(space_s1),
		.no_pulse (none_s1),
		.state_nxt(state_nxt),
		.emit     (emit),
		.result   (result)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.in_frame <= 1'b0;
			state_q.fmt      <= irfd_pkg::FMT_UNKNOWN;
			state_q.bit_idx  <= '0;
			state_q.accum    <= '0;
			state_q.count    <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.total, out_q.value};
	assign m_tuser  = {out_q.fmt, out_q.kind};
	assign m_tlast  = out_q.done;

endmodule

// ----- rtl/irfd_step.sv -----
// Decode of one pulse record: next decoder state and the optional result.
module irfd_step #(
	parameter int unsigned MAX_FRAME_BYTES = irfd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  irfd_pkg::dec_state_t             state,
	input  irfd_pkg::cfg_t                   cfg,
	input  logic [irfd_pkg::LEN_W-1:0]       mark_len,
	input  logic [irfd_pkg::LEN_W-1:0]       space_len,
	input  logic                             no_pulse,
	output irfd_pkg::dec_state_t             state_nxt,
	output logic                             emit,
	output irfd_pkg::result_t                result
);

	localparam logic [irfd_pkg::COUNT_W-1:0] MAX_BYTES =
		irfd_pkg::COUNT_W'(MAX_FRAME_BYTES);

	// Half-width window test on doubled space: nom < 2s < 3*nom
	function automatic logic in_window(input logic [irfd_pkg::NOM_W-1:0] nom,
			input logic [irfd_pkg::LEN_W:0] twice);
		logic [irfd_pkg::NOM_W+1:0] three;
		three = {2'b00, nom} + {1'b0, nom, 1'b0};
		return ({7'd0, nom} < twice) && ({5'd0, three} > twice);
	endfunction

	irfd_pkg::fmt_t                    lead_fmt;
	logic [irfd_pkg::LEN_W:0]          twice;
	logic [irfd_pkg::NOM_W-1:0]        l0, l1;
	logic [irfd_pkg::STOP_W-1:0]       stop;
	logic                              bit_zero, bit_one, is_stop, is_repeat;
	logic [7:0]                        accum_nxt;
	logic [irfd_pkg::COUNT_W-1:0]      count_inc;

	// Leader classification
	always_comb begin
		if (mark_len > irfd_pkg::AEHA_MARK_LO && mark_len < irfd_pkg::AEHA_MARK_HI) begin
			lead_fmt = irfd_pkg::FMT_AEHA;
		end else if (mark_len > irfd_pkg::NEC_MARK_LO && mark_len < irfd_pkg::NEC_MARK_HI) begin
			lead_fmt = irfd_pkg::FMT_NEC;
		end else if (mark_len > irfd_pkg::SONY_MARK_LO && mark_len < irfd_pkg::SONY_MARK_HI) begin
			lead_fmt = irfd_pkg::FMT_SONY;
		end else begin
			lead_fmt = irfd_pkg::FMT_UNKNOWN;
		end
	end

	assign is_repeat = (lead_fmt == irfd_pkg::FMT_AEHA && space_len > irfd_pkg::AEHA_RPT_SPACE) ||
		(lead_fmt == irfd_pkg::FMT_NEC && space_len < irfd_pkg::NEC_RPT_SPACE);

	// Bit windows for the format of the running frame
	assign twice = {space_len, 1'b0};
	assign l0    = (state.fmt == irfd_pkg::FMT_AEHA) ? cfg.aeha_zero : cfg.nec_zero;
	assign l1    = (state.fmt == irfd_pkg::FMT_AEHA) ? cfg.aeha_one  : cfg.nec_one;
	assign stop  = (state.fmt == irfd_pkg::FMT_AEHA) ? cfg.aeha_stop : cfg.nec_stop;

	assign bit_zero  = in_window(l0, twice);
	assign bit_one   = !bit_zero && in_window(l1, twice);
	assign is_stop   = !bit_zero && !bit_one && (space_len > stop);
	assign accum_nxt = state.accum | ({7'd0, bit_one} << state.bit_idx);
	assign count_inc = state.count + 1'b1;

	// Next state and result
	always_comb begin
		state_nxt     = state;
		emit          = 1'b0;
		result.kind   = irfd_pkg::KIND_DATA;
		result.value  = 8'd0;
		result.done   = 1'b1;
		result.total  = '0;
		result.fmt    = state.fmt;
		if (!state.in_frame) begin
			if (no_pulse) begin
				emit        = 1'b1;
				result.kind = irfd_pkg::KIND_NO_LEADER;
			end else begin
				state_nxt.fmt = lead_fmt;
				result.fmt    = lead_fmt;
				if (is_repeat) begin
					emit        = 1'b1;
					result.kind = irfd_pkg::KIND_REPEAT;
				end else if (lead_fmt != irfd_pkg::FMT_AEHA && lead_fmt != irfd_pkg::FMT_NEC) begin
					emit        = 1'b1;
					result.kind = irfd_pkg::KIND_UNSUP;
				end else begin
					state_nxt.in_frame = 1'b1;
					state_nxt.bit_idx  = '0;
					state_nxt.accum    = '0;
					state_nxt.count    = '0;
				end
			end
		end else if (no_pulse || is_stop) begin
			state_nxt.in_frame = 1'b0;
			emit               = 1'b1;
			result.kind        = irfd_pkg::KIND_FRAME_END;
			result.total       = state.count;
		end else if (state.bit_idx == 3'd7) begin
			// byte complete
			state_nxt.bit_idx = '0;
			state_nxt.accum   = '0;
			state_nxt.count   = count_inc;
			emit              = 1'b1;
			result.kind       = irfd_pkg::KIND_DATA;
			result.value      = accum_nxt;
			result.total      = count_inc;
			result.done       = (count_inc >= MAX_BYTES);
			if (count_inc >= MAX_BYTES) begin
				state_nxt.in_frame = 1'b0;
			end
		end else begin
			state_nxt.bit_idx = state.bit_idx + 1'b1;
			state_nxt.accum   = accum_nxt;
		end
	end

endmodule

// ----- rtl/irfd_checker.sv -----
// Port-level checks for the IR frame decoder.
module irfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [4:0]  m_tuser,
	input logic        m_tlast
);

	// Stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed under backpressure");

	// Every non-data result closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != irfd_pkg::KIND_DATA) |-> m_tlast)
		else $error("non-data result without frame end");

	// Only data results carry a byte value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != irfd_pkg::KIND_DATA) |-> m_tdata[7:0] == 8'd0)
		else $error("byte value on non-data result");

	// Idle-state results report no byte count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == irfd_pkg::KIND_REPEAT
			|| m_tuser[2:0] == irfd_pkg::KIND_UNSUP
			|| m_tuser[2:0] == irfd_pkg::KIND_NO_LEADER) |-> m_tdata[14:8] == 7'd0)
		else $error("byte count on idle result");

endmodule

bind ir_remote_frame_decoder_top irfd_checker u_irfd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
